// File: rtl/krhm_pkg.sv
// ----------------------------------------------------------------------------
// krhm_pkg
// Shared types and constants for the kick ramp / heading hold wheel mixer.
// ----------------------------------------------------------------------------
package krhm_pkg;

	// defaults for the top-level parameters
	localparam int unsigned MAX_PWM_DEF     = 255;
	localparam int unsigned REAR_FLOOR_DEF  = 0;
	localparam int unsigned INVERT_MASK_DEF = 0;

	// heading units are 1/64 degree
	localparam logic signed [15:0] HALF_TURN = 16'sd11520;
	localparam logic signed [15:0] FULL_TURN = 16'sd23040;

	// register indexes
	localparam logic [2:0] CFG_START    = 3'd0;
	localparam logic [2:0] CFG_STEP     = 3'd1;
	localparam logic [2:0] CFG_INTERVAL = 3'd2;
	localparam logic [2:0] CFG_FINAL    = 3'd3;
	localparam logic [2:0] CFG_FRESH    = 3'd4;
	localparam logic [2:0] CFG_GAIN     = 3'd5;
	localparam logic [2:0] CFG_LIMIT    = 3'd6;
	localparam logic [2:0] CFG_TRIM     = 3'd7;

	// bridge direction codes
	localparam logic [1:0] DIR_BRAKE = 2'd0;
	localparam logic [1:0] DIR_POS   = 2'd1;
	localparam logic [1:0] DIR_NEG   = 2'd2;

	localparam int WHL_W = 11; // signed wheel drive before scaling
	localparam int MAG_W = 10; // its magnitude
	localparam int NUM_W = 18; // magnitude times MAX_PWM
	localparam int QUO_W = 8;  // scaled magnitude
	localparam logic [1:0] WHEEL_LAST = 2'd2;

	typedef struct packed {
		logic [7:0]         start;
		logic [7:0]         step;
		logic [15:0]        interval;
		logic [7:0]         final_pwm;
		logic [15:0]        fresh;
		logic signed [15:0] gain;
		logic [7:0]         limit;
		logic signed [8:0]  trim;
	} cfg_t;

	typedef struct packed {
		logic       capture;
		logic       update;
		logic       mul;
		logic       corr;
		logic       mix;
		logic       div_load;
		logic       div_step;
		logic       div_last;
		logic       load_out;
		logic [1:0] wheel;
	} dp_cmd_t;

	typedef struct packed {
		logic stop;
		logic scale;
	} dp_sts_t;

endpackage

// File: rtl/krhm_cfg.sv
// ----------------------------------------------------------------------------
// krhm_cfg
// Configuration register file, written through a valid/ready port.
// ----------------------------------------------------------------------------
module krhm_cfg
	import krhm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t regs_q;

	assign cfg_ready = 1'b1;
	assign cfg = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.start     <= 8'd120;
			regs_q.step      <= 8'd40;
			regs_q.interval  <= 16'd4;
			regs_q.final_pwm <= 8'd240;
			regs_q.fresh     <= 16'd100;
			regs_q.gain      <= 16'sd256;
			regs_q.limit     <= 8'd60;
			regs_q.trim      <= 9'sd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_START:    regs_q.start     <= cfg_data[7:0];
				CFG_STEP:     regs_q.step      <= cfg_data[7:0];
				CFG_INTERVAL: regs_q.interval  <= cfg_data;
				CFG_FINAL:    regs_q.final_pwm <= cfg_data[7:0];
				CFG_FRESH:    regs_q.fresh     <= cfg_data;
				CFG_GAIN:     regs_q.gain      <= $signed(cfg_data);
				CFG_LIMIT:    regs_q.limit     <= cfg_data[7:0];
				CFG_TRIM:     regs_q.trim      <= $signed(cfg_data[8:0]);
				default:      regs_q <= regs_q;
			endcase
		end
	end

endmodule

// File: rtl/krhm_ctrl.sv
// ----------------------------------------------------------------------------
// krhm_ctrl
// Sequencer: steps the datapath through one tick and owns the output valid.
// ----------------------------------------------------------------------------
module krhm_ctrl
	import krhm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	input  dp_sts_t sts,
	output dp_cmd_t dp_cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_UPD   = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_CORR  = 3'd3;
	localparam logic [2:0] ST_MIX   = 3'd4;
	localparam logic [2:0] ST_DLD   = 3'd5;
	localparam logic [2:0] ST_DSTEP = 3'd6;
	localparam logic [2:0] ST_FIN   = 3'd7;

	logic [2:0] state_q, state_nxt;
	logic [2:0] bit_q;
	logic [1:0] wheel_q;
	logic       out_valid_q;
	logic       out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		dp_cmd       = '0;
		dp_cmd.wheel = wheel_q;
		state_nxt    = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					dp_cmd.capture = 1'b1;
					state_nxt      = ST_UPD;
				end
			end
			ST_UPD: begin
				dp_cmd.update = 1'b1;
				state_nxt     = sts.stop ? ST_FIN : ST_MUL;
			end
			ST_MUL: begin
				dp_cmd.mul = 1'b1;
				state_nxt  = ST_CORR;
			end
			ST_CORR: begin
				dp_cmd.corr = 1'b1;
				state_nxt   = ST_MIX;
			end
			ST_MIX: begin
				dp_cmd.mix = 1'b1;
				state_nxt  = ST_DLD;
			end
			ST_DLD: begin
				if (!sts.scale) begin
					state_nxt = ST_FIN;
				end else begin
					dp_cmd.div_load = 1'b1;
					state_nxt       = ST_DSTEP;
				end
			end
			ST_DSTEP: begin
				dp_cmd.div_step = 1'b1;
				if (bit_q == 3'd0) begin
					dp_cmd.div_last = 1'b1;
					state_nxt = (wheel_q == WHEEL_LAST) ? ST_FIN : ST_DLD;
				end
			end
			ST_FIN: begin
				// hold the result here until the output register frees up
				if (out_free) begin
					dp_cmd.load_out = 1'b1;
					state_nxt       = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bit_q       <= 3'd0;
			wheel_q     <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (dp_cmd.capture)
				wheel_q <= 2'd0;
			else if (dp_cmd.div_last)
				wheel_q <= wheel_q + 2'd1;
			if (dp_cmd.div_load)
				bit_q <= 3'd7;
			else if (dp_cmd.div_step)
				bit_q <= bit_q - 3'd1;
			if (dp_cmd.load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// File: rtl/krhm_dp.sv
// ----------------------------------------------------------------------------
// krhm_dp
// Datapath: ramp state, heading error, gain multiply, mixing, shared
// restoring divider for wheel scaling, and the output register.
// ----------------------------------------------------------------------------
module krhm_dp
	import krhm_pkg::*;
#(
	parameter int unsigned MAX_PWM     = MAX_PWM_DEF,
	parameter int unsigned REAR_FLOOR  = REAR_FLOOR_DEF,
	parameter int unsigned INVERT_MASK = INVERT_MASK_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            dp_cmd,
	output dp_sts_t            sts,
	input  cfg_t               cfg,
	input  logic               cmd,
	input  logic [31:0]        now_ms,
	input  logic signed [14:0] heading,
	input  logic [7:0]         confidence,
	input  logic [31:0]        pose_time_ms,
	output logic [1:0]         dir_left,
	output logic [7:0]         pwm_left,
	output logic [1:0]         dir_right,
	output logic [7:0]         pwm_right,
	output logic [1:0]         dir_rear,
	output logic [7:0]         pwm_rear,
	output logic signed [8:0]  correction,
	output logic signed [14:0] heading_error
);

	localparam logic [QUO_W-1:0] MAXV   = QUO_W'(MAX_PWM);
	localparam logic [MAG_W-1:0] MAXM   = MAG_W'(MAX_PWM);
	localparam logic [MAG_W-1:0] FLOORM = MAG_W'(REAR_FLOOR);
	localparam logic [2:0]       INV    = 3'(INVERT_MASK);

	// ramp state
	logic               active_q;
	logic [7:0]         thrust_q;
	logic [31:0]        last_q;
	logic signed [14:0] target_q;
	logic               trusted_q;

	// captured word
	logic               stop_q;
	logic [31:0]        now_q, pose_q;
	logic signed [14:0] head_q;
	logic [7:0]         conf_q;

	// working registers
	logic signed [14:0] err_q;
	logic signed [30:0] prod_q;
	logic signed [8:0]  corr_q;
	logic [MAG_W-1:0]   mag_q [3];
	logic [2:0]         neg_q;
	logic [MAG_W-1:0]   peak_q;
	logic               scale_q;
	logic [NUM_W-1:0]   num_q, dvs_q;
	logic [QUO_W-1:0]   quo_q;

	// output register
	logic [1:0]         dir_q [3];
	logic [7:0]         pwm_q [3];
	logic signed [8:0]  corr_out_q;
	logic signed [14:0] err_out_q;

	// tick update
	logic               entry;
	logic [7:0]         thr_base, thr_next;
	logic [8:0]         thr_sum;
	logic [31:0]        last_base, last_next, age, elapsed;
	logic signed [14:0] tgt_base;
	logic               trusted_base, fresh_ok, tick, use_sensor;
	logic signed [15:0] diff, wrapped;
	logic signed [14:0] err_next;

	always_comb begin
		entry        = !active_q;
		age          = now_q - pose_q;
		fresh_ok     = age < {16'd0, cfg.fresh};
		thr_base     = entry ? cfg.start : thrust_q;
		last_base    = entry ? now_q : last_q;
		tgt_base     = entry ? head_q : target_q;
		trusted_base = entry ? ((conf_q != 8'd0) && (pose_q != 32'd0) && fresh_ok)
		                     : trusted_q;
		elapsed      = now_q - last_base;
		tick         = elapsed >= {16'd0, cfg.interval};
		thr_sum      = {1'b0, thr_base} + {1'b0, cfg.step};
		thr_next     = thr_base;
		if (tick && (thr_base < cfg.final_pwm))
			thr_next = (thr_sum > {1'b0, cfg.final_pwm}) ? cfg.final_pwm : thr_sum[7:0];
		last_next    = tick ? now_q : last_base;
		use_sensor   = trusted_base && (conf_q != 8'd0) && fresh_ok;
		// one wrap is enough: the raw difference stays under one and a half turns
		diff         = {head_q[14], head_q} - {tgt_base[14], tgt_base};
		if (diff > HALF_TURN)
			wrapped = diff - FULL_TURN;
		else if (diff < -HALF_TURN)
			wrapped = diff + FULL_TURN;
		else
			wrapped = diff;
		err_next = use_sensor ? wrapped[14:0] : 15'sd0;
	end

	// correction: truncate toward zero, then clamp
	logic signed [30:0] prod_adj;
	logic signed [16:0] corr_raw, lim_pos, lim_neg, corr_clamp;

	always_comb begin
		prod_adj = prod_q + (prod_q[30] ? 31'sd16383 : 31'sd0);
		corr_raw = prod_adj[30:14];
		lim_pos  = $signed({9'd0, cfg.limit});
		lim_neg  = -lim_pos;
		if (corr_raw > lim_pos)
			corr_clamp = lim_pos;
		else if (corr_raw < lim_neg)
			corr_clamp = lim_neg;
		else
			corr_clamp = corr_raw;
	end

	// mixing
	logic signed [WHL_W-1:0] whl [3];
	logic [MAG_W-1:0]        whl_mag [3];
	logic [MAG_W-1:0]        peak;

	always_comb begin
		whl[0] = $signed({3'd0, thrust_q}) - {{2{cfg.trim[8]}}, cfg.trim}
		         + {{2{corr_q[8]}}, corr_q};
		whl[1] = {{2{corr_q[8]}}, corr_q} - $signed({3'd0, thrust_q})
		         - {{2{cfg.trim[8]}}, cfg.trim};
		whl[2] = {{2{corr_q[8]}}, corr_q};
		peak = '0;
		for (int i = 0; i < 3; i++) begin
			whl_mag[i] = whl[i][WHL_W-1] ? MAG_W'(-whl[i]) : MAG_W'(whl[i]);
			if (whl_mag[i] > peak)
				peak = whl_mag[i];
		end
	end

	// divider step
	logic div_ge;
	assign div_ge = num_q >= dvs_q;

	// final drive codes
	logic [MAG_W-1:0] fin_mag [3];
	logic [1:0]       fin_dir [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fin_mag[i] = mag_q[i];
			if ((i == 2) && (FLOORM != '0) && (fin_mag[i] != '0) && (fin_mag[i] < FLOORM))
				fin_mag[i] = FLOORM;
			if (fin_mag[i] > MAXM)
				fin_mag[i] = MAXM;
			if (fin_mag[i] == '0)
				fin_dir[i] = DIR_BRAKE;
			else if (neg_q[i] ^ INV[i])
				fin_dir[i] = DIR_NEG;
			else
				fin_dir[i] = DIR_POS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			thrust_q  <= 8'd0;
			last_q    <= 32'd0;
			target_q  <= 15'sd0;
			trusted_q <= 1'b0;
		end else if (dp_cmd.update) begin
			if (stop_q) begin
				active_q <= 1'b0;
			end else begin
				active_q  <= 1'b1;
				thrust_q  <= thr_next;
				last_q    <= last_next;
				target_q  <= tgt_base;
				trusted_q <= trusted_base;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.capture) begin
			stop_q <= cmd;
			now_q  <= now_ms;
			head_q <= heading;
			conf_q <= confidence;
			pose_q <= pose_time_ms;
		end
		if (dp_cmd.update)
			err_q <= err_next;
		if (dp_cmd.mul)
			prod_q <= 31'($signed(cfg.gain)) * 31'(err_q);
		if (dp_cmd.corr)
			corr_q <= corr_clamp[8:0];
		if (dp_cmd.mix) begin
			for (int i = 0; i < 3; i++) begin
				mag_q[i] <= whl_mag[i];
				neg_q[i] <= whl[i][WHL_W-1];
			end
			peak_q  <= peak;
			scale_q <= peak > MAXM;
		end
		if (dp_cmd.div_load) begin
			num_q <= {{(NUM_W-MAG_W){1'b0}}, mag_q[dp_cmd.wheel]}
			         * {{(NUM_W-QUO_W){1'b0}}, MAXV};
			dvs_q <= {{(NUM_W-MAG_W-7){1'b0}}, peak_q, 7'd0};
			quo_q <= '0;
		end else if (dp_cmd.div_step) begin
			num_q <= div_ge ? num_q - dvs_q : num_q;
			dvs_q <= dvs_q >> 1;
			quo_q <= {quo_q[QUO_W-2:0], div_ge};
			if (dp_cmd.div_last)
				mag_q[dp_cmd.wheel] <= {{(MAG_W-QUO_W){1'b0}}, quo_q[QUO_W-2:0], div_ge};
		end
		if (dp_cmd.load_out) begin
			for (int i = 0; i < 3; i++) begin
				dir_q[i] <= stop_q ? DIR_BRAKE : fin_dir[i];
				pwm_q[i] <= stop_q ? 8'd0 : fin_mag[i][7:0];
			end
			corr_out_q <= stop_q ? 9'sd0 : corr_q;
			err_out_q  <= stop_q ? 15'sd0 : err_q;
		end
	end

	assign sts.stop      = stop_q;
	assign sts.scale     = scale_q;
	assign dir_left      = dir_q[0];
	assign pwm_left      = pwm_q[0];
	assign dir_right     = dir_q[1];
	assign pwm_right     = pwm_q[1];
	assign dir_rear      = dir_q[2];
	assign pwm_rear      = pwm_q[2];
	assign correction    = corr_out_q;
	assign heading_error = err_out_q;

endmodule

// File: rtl/kick_ramp_heading_hold_mixer_core.sv
// ----------------------------------------------------------------------------
// kick_ramp_heading_hold_mixer_core
// Kick thrust ramp with proportional heading hold, mixed onto three wheels.
// ----------------------------------------------------------------------------
//  channel  handshake             word
//  cfg      cfg_valid/cfg_ready   cfg_index, cfg_data
//  in       in_valid/in_stall     cmd, now_ms, heading, confidence, pose_time_ms
//  out      out_valid/out_stall   dir_*/pwm_* per wheel, correction, heading_error
//
//  A stop word passes the update and finish states, a kick word update, multiply,
//  correction, mix and divider load before finish; its result reaches the output
//  register as the block returns to idle. When a wheel exceeds MAX_PWM the shared
//  restoring divider scales each wheel in turn: a load, then the quotient bits.
//  in_stall is high while a word is in work; a new word is taken once the
//  result sits in the output register, even if out_stall holds it there.
//  Reset is asynchronous, active low; cfg_ready is always high.
// ----------------------------------------------------------------------------
module kick_ramp_heading_hold_mixer_core
	import krhm_pkg::*;
#(
	parameter int unsigned MAX_PWM     = MAX_PWM_DEF,
	parameter int unsigned REAR_FLOOR  = REAR_FLOOR_DEF,
	parameter int unsigned INVERT_MASK = INVERT_MASK_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  logic [31:0]        now_ms,
	input  logic signed [14:0] heading,
	input  logic [7:0]         confidence,
	input  logic [31:0]        pose_time_ms,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         dir_left,
	output logic [7:0]         pwm_left,
	output logic [1:0]         dir_right,
	output logic [7:0]         pwm_right,
	output logic [1:0]         dir_rear,
	output logic [7:0]         pwm_rear,
	output logic signed [8:0]  correction,
	output logic signed [14:0] heading_error
);

	cfg_t    cfg;
	dp_cmd_t dp_cmd;
	dp_sts_t sts;

	krhm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	krhm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.dp_cmd    (dp_cmd)
	);

	krhm_dp #(
		.MAX_PWM     (MAX_PWM),
		.REAR_FLOOR  (REAR_FLOOR),
		.INVERT_MASK (INVERT_MASK)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.dp_cmd        (dp_cmd),
		.sts           (sts),
		.cfg           (cfg),
		.cmd           (cmd),
		.now_ms        (now_ms),
		.heading       (heading),
		.confidence    (confidence),
		.pose_time_ms  (pose_time_ms),
		.dir_left      (dir_left),
		.pwm_left      (pwm_left),
		.dir_right     (dir_right),
		.pwm_right     (pwm_right),
		.dir_rear      (dir_rear),
		.pwm_rear      (pwm_rear),
		.correction    (correction),
		.heading_error (heading_error)
	);

endmodule

// File: rtl/krhm_checker.sv
// ----------------------------------------------------------------------------
// krhm_checker
// Port-level checks on the mixer core, bound to the top level.
// ----------------------------------------------------------------------------
module krhm_checker
	import krhm_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [1:0]         dir_left,
	input logic [7:0]         pwm_left,
	input logic [1:0]         dir_right,
	input logic [7:0]         pwm_right,
	input logic [1:0]         dir_rear,
	input logic [7:0]         pwm_rear,
	input logic signed [8:0]  correction,
	input logic signed [14:0] heading_error
);

	// a held word keeps its magnitudes, correction and heading error
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pwm_left) && $stable(pwm_right)
		&& $stable(pwm_rear) && $stable(correction) && $stable(heading_error))
		else $error("stalled output word changed");

	// brake code and zero magnitude go together
	a_brake_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((dir_left == DIR_BRAKE) == (pwm_left == 8'd0))
		&& ((dir_right == DIR_BRAKE) == (pwm_right == 8'd0))
		&& ((dir_rear == DIR_BRAKE) == (pwm_rear == 8'd0)))
		else $error("direction code disagrees with magnitude");

	// no heading error means no correction
	a_corr_needs_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (heading_error == 15'sd0) |-> correction == 9'sd0)
		else $error("correction without heading error");

	// a word taken at the input is never followed by an input accept next cycle
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second word accepted while one is in work");

endmodule

bind kick_ramp_heading_hold_mixer_core krhm_checker u_krhm_checker (.*);

// File: bench/kick_ramp_heading_hold_mixer_core_test.sv
// ----------------------------------------------------------------------------
// kick_ramp_heading_hold_mixer_core_test
// Self-checking bench for the kick ramp / heading hold wheel mixer. A short
// directed run at reset settings is followed by eight register settings, each
// with a burst of random kick runs, stops and noise words. Every accepted
// input word runs through a behavioral mixer in the bench, and each output
// word is compared field by field with the oldest predicted drive word.
// ----------------------------------------------------------------------------
module kick_ramp_heading_hold_mixer_core_test;
	import krhm_pkg::*;

	localparam int PWM_CEIL   = MAX_PWM_DEF;
	localparam int REAR_MIN   = REAR_FLOOR_DEF;
	localparam int FLIP_MASK  = INVERT_MASK_DEF;
	localparam logic CMD_KICK = 1'b0;
	localparam logic CMD_STOP = 1'b1;
	localparam int PHASES     = 8;
	localparam int PHASE_TICKS = 180;
	localparam int HOLD_OFF_AT = 650;
	localparam int HOLD_OFF_CYCLES = 500;
	localparam int DRAIN_CYCLES = 40;
	localparam longint RUN_LIMIT = 64'd16_000_000;

	typedef struct packed {
		logic               cmd;
		logic [31:0]        now_ms;
		logic signed [14:0] heading;
		logic [7:0]         confidence;
		logic [31:0]        pose_time_ms;
	} tick_t;

	typedef struct packed {
		logic [1:0]         dir_left;
		logic [7:0]         pwm_left;
		logic [1:0]         dir_right;
		logic [7:0]         pwm_right;
		logic [1:0]         dir_rear;
		logic [7:0]         pwm_rear;
		logic signed [8:0]  correction;
		logic signed [14:0] heading_error;
	} drive_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = '0;
	logic [15:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               cmd = 1'b0;
	logic [31:0]        now_ms = '0;
	logic signed [14:0] heading = '0;
	logic [7:0]         confidence = '0;
	logic [31:0]        pose_time_ms = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         dir_left;
	logic [7:0]         pwm_left;
	logic [1:0]         dir_right;
	logic [7:0]         pwm_right;
	logic [1:0]         dir_rear;
	logic [7:0]         pwm_rear;
	logic signed [8:0]  correction;
	logic signed [14:0] heading_error;

	kick_ramp_heading_hold_mixer_core #(
		.MAX_PWM    (MAX_PWM_DEF),
		.REAR_FLOOR (REAR_FLOOR_DEF),
		.INVERT_MASK(INVERT_MASK_DEF)
	) dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// mixer state and register copy kept by the bench
	cfg_t knobs = '{start: 8'd120, step: 8'd40, interval: 16'd4, final_pwm: 8'd240,
		fresh: 16'd100, gain: 16'sd256, limit: 8'd60, trim: 9'sd0};
	logic               ramping = 1'b0;
	logic [7:0]         thrust = '0;
	logic [31:0]        last_step = '0;
	logic signed [14:0] aim = '0;
	logic               trusted = 1'b0;

	tick_t  tick_backlog [$];
	drive_t drive_due [$];
	tick_t  next_tick;
	logic [15:0] setting [8];
	int ticks_queued = 0;
	int ticks_taken = 0;
	int mismatches = 0;
	int send_gap = 0;
	int out_hold_left = 0;
	logic hold_off = 1'b0;

	function automatic logic [9:0] bridge(int w, int idx);
		logic [1:0] code;
		int mag;
		mag = (w < 0) ? -w : w;
		code = (w > 0) ? DIR_POS : ((w < 0) ? DIR_NEG : DIR_BRAKE);
		if (code != DIR_BRAKE && ((FLIP_MASK >> idx) & 1) != 0)
			code = (code == DIR_POS) ? DIR_NEG : DIR_POS;
		if (mag > PWM_CEIL)
			mag = PWM_CEIL;
		return {code, mag[7:0]};
	endfunction

	function automatic drive_t mix_tick(tick_t t);
		drive_t d;
		logic [31:0] age;
		logic [31:0] since;
		logic fresh_pose;
		int err, corr, peak, lim, ramped, i;
		int w [3];
		longint c;
		d = '0;
		err = 0;
		corr = 0;
		peak = 0;
		if (t.cmd == CMD_STOP) begin
			ramping = 1'b0;
			return d;
		end
		age = t.now_ms - t.pose_time_ms;
		fresh_pose = (t.confidence != 8'd0) && (age < knobs.fresh);
		// first kick after a stop latches the target and the sensor's health
		if (!ramping) begin
			ramping = 1'b1;
			thrust = knobs.start;
			last_step = t.now_ms;
			aim = t.heading;
			trusted = fresh_pose && (t.pose_time_ms != 32'd0);
		end
		since = t.now_ms - last_step;
		if (since >= knobs.interval) begin
			last_step = t.now_ms;
			if (thrust < knobs.final_pwm) begin
				ramped = int'(thrust) + int'(knobs.step);
				if (ramped > int'(knobs.final_pwm))
					ramped = int'(knobs.final_pwm);
				thrust = ramped[7:0];
			end
		end
		if (trusted && fresh_pose) begin
			err = int'($signed(t.heading)) - int'($signed(aim));
			while (err > int'(HALF_TURN)) err -= int'(FULL_TURN);
			while (err < -int'(HALF_TURN)) err += int'(FULL_TURN);
			c = (longint'($signed(knobs.gain)) * longint'(err)) / 16384;
			lim = int'(knobs.limit);
			if (c > lim) c = longint'(lim);
			if (c < -lim) c = -longint'(lim);
			corr = int'(c);
		end
		w[0] = int'(thrust) - int'($signed(knobs.trim)) + corr;
		w[1] = -(int'(thrust) + int'($signed(knobs.trim))) + corr;
		w[2] = corr;
		for (i = 0; i < 3; i++)
			if (((w[i] < 0) ? -w[i] : w[i]) > peak)
				peak = (w[i] < 0) ? -w[i] : w[i];
		// scale all wheels together so the largest sits at the ceiling
		if (peak > PWM_CEIL)
			for (i = 0; i < 3; i++)
				w[i] = int'((longint'(w[i]) * PWM_CEIL) / peak);
		if (REAR_MIN > 0 && w[2] != 0 && ((w[2] < 0) ? -w[2] : w[2]) < REAR_MIN)
			w[2] = (w[2] < 0) ? -REAR_MIN : REAR_MIN;
		{d.dir_left, d.pwm_left} = bridge(w[0], 0);
		{d.dir_right, d.pwm_right} = bridge(w[1], 1);
		{d.dir_rear, d.pwm_rear} = bridge(w[2], 2);
		d.correction = corr[8:0];
		d.heading_error = err[14:0];
		return d;
	endfunction

	function automatic void apply_knob(logic [2:0] idx, logic [15:0] v);
		case (idx)
			CFG_START:    knobs.start = v[7:0];
			CFG_STEP:     knobs.step = v[7:0];
			CFG_INTERVAL: knobs.interval = v;
			CFG_FINAL:    knobs.final_pwm = v[7:0];
			CFG_FRESH:    knobs.fresh = v;
			CFG_GAIN:     knobs.gain = v;
			CFG_LIMIT:    knobs.limit = v[7:0];
			CFG_TRIM:     knobs.trim = v[8:0];
			default: ;
		endcase
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// mostly short pauses, a few long ones; none during the calm stretches
	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (((ticks_taken / 128) % 5) == 2) return 0;
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 15);
		return $urandom_range(30, 120);
	endfunction

	function automatic void queue_tick(logic c, logic [31:0] at_ms, int hd,
			logic [7:0] conf, logic [31:0] pose);
		tick_t t;
		t.cmd = c;
		t.now_ms = at_ms;
		t.heading = hd[14:0];
		t.confidence = conf;
		t.pose_time_ms = pose;
		tick_backlog.push_back(t);
		ticks_queued++;
	endfunction

	function automatic void put_setting(int start, int step, int interval, int final_pwm,
			int fresh, int gain, int limit, int trim);
		setting[CFG_START] = 16'(start);
		setting[CFG_STEP] = 16'(step);
		setting[CFG_INTERVAL] = 16'(interval);
		setting[CFG_FINAL] = 16'(final_pwm);
		setting[CFG_FRESH] = 16'(fresh);
		setting[CFG_GAIN] = 16'(gain);
		setting[CFG_LIMIT] = 16'(limit);
		setting[CFG_TRIM] = 16'(trim);
	endfunction

	// input driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (tick_backlog.size() != 0) begin
				next_tick = tick_backlog.pop_front();
				in_valid <= 1'b1;
				cmd <= next_tick.cmd;
				now_ms <= next_tick.now_ms;
				heading <= next_tick.heading;
				confidence <= next_tick.confidence;
				pose_time_ms <= next_tick.pose_time_ms;
				send_gap = pause_len();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output back-pressure
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_off) begin
			out_stall <= 1'b1;
		end else begin
			if (out_hold_left == 0 && $urandom_range(0, 4) == 0)
				out_hold_left = pause_len();
			out_stall <= (out_hold_left != 0);
			if (out_hold_left != 0)
				out_hold_left--;
		end
	end

	// register writes and accepted words feed the prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				apply_knob(cfg_index, cfg_data);
			if (in_valid && !in_stall) begin
				drive_due.push_back(mix_tick(tick_t'{cmd, now_ms, heading, confidence,
					pose_time_ms}));
				ticks_taken++;
			end
		end
	end

	// output monitor
	always @(posedge clk) begin
		drive_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (drive_due.size() == 0) begin
				$error("output word with no prediction pending");
				mismatches++;
			end else begin
				want = drive_due.pop_front();
				check_field("dir_left", int'(want.dir_left), int'(dir_left));
				check_field("pwm_left", int'(want.pwm_left), int'(pwm_left));
				check_field("dir_right", int'(want.dir_right), int'(dir_right));
				check_field("pwm_right", int'(want.pwm_right), int'(pwm_right));
				check_field("dir_rear", int'(want.dir_rear), int'(dir_rear));
				check_field("pwm_rear", int'(want.pwm_rear), int'(pwm_rear));
				check_field("correction", int'($signed(want.correction)),
					int'($signed(correction)));
				check_field("heading_error", int'($signed(want.heading_error)),
					int'($signed(heading_error)));
			end
		end
	end

	// long receiver hold-off while the sender keeps offering
	initial begin
		wait (ticks_taken >= HOLD_OFF_AT);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_OFF_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#(RUN_LIMIT);
		$display("kick_ramp_heading_hold_mixer_core_test: done, errors");
		$finish;
	end

	task automatic settle();
		do @(negedge clk);
		while (tick_backlog.size() != 0 || in_valid || drive_due.size() != 0);
	endtask

	task automatic write_setting();
		int i;
		@(posedge clk);
		for (i = int'(CFG_START); i <= int'(CFG_TRIM); i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= i[2:0];
			cfg_data <= setting[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// kick runs with random content, plus stops and raw noise words
	task automatic make_traffic(int quota);
		int goal, r, run, k, dt, base, hd;
		logic [31:0] clock_ms, age;
		goal = ticks_queued + quota;
		clock_ms = $urandom;
		while (ticks_queued < goal) begin
			r = $urandom_range(0, 99);
			if (r < 78) begin
				if ($urandom_range(0, 9) < 7)
					queue_tick(CMD_STOP, clock_ms, int'($urandom_range(0, 32767)) - 16384,
						8'($urandom), $urandom);
				if ($urandom_range(0, 9) == 0)
					clock_ms = $urandom;
				base = int'($urandom_range(0, 23040)) - 11520;
				run = $urandom_range(1, 24);
				for (k = 0; k < run && ticks_queued < goal; k++) begin
					r = $urandom_range(0, 99);
					if (r < 60) dt = $urandom_range(0, 6);
					else if (r < 88) dt = $urandom_range(0, setting[CFG_INTERVAL] + 2);
					else dt = $urandom;
					clock_ms = clock_ms + dt;
					base = base + int'($urandom_range(0, 400)) - 200;
					if ($urandom_range(0, 99) < 8)
						hd = int'($urandom_range(0, 32767)) - 16384;
					else
						hd = base + int'($urandom_range(0, 4000)) - 2000;
					r = $urandom_range(0, 99);
					if (r < 75) age = $urandom_range(0, setting[CFG_FRESH] + 3);
					else if (r < 83) age = 32'(setting[CFG_FRESH]);
					else if (r < 95) age = $urandom;
					else age = clock_ms; // pose time zero: no pose yet
					queue_tick(CMD_KICK, clock_ms, hd,
						($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255)),
						clock_ms - age);
				end
			end else if (r < 90) begin
				queue_tick(1'($urandom_range(0, 1)), $urandom,
					int'($urandom_range(0, 32767)) - 16384, 8'($urandom), $urandom);
			end else begin
				run = $urandom_range(1, 3);
				for (k = 0; k < run && ticks_queued < goal; k++)
					queue_tick(CMD_STOP, $urandom, int'($urandom_range(0, 32767)) - 16384,
						8'($urandom), $urandom);
			end
		end
	endtask

	initial begin
		int p;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: ramp steps, clamp, wrap, stale and missing pose
		queue_tick(CMD_STOP, 32'd0, 0, 8'd0, 32'd0);
		queue_tick(CMD_KICK, 32'd1000, 0, 8'd200, 32'd990);
		queue_tick(CMD_KICK, 32'd1004, 640, 8'd200, 32'd1000);
		queue_tick(CMD_KICK, 32'd1008, -11520, 8'd255, 32'd1008);
		queue_tick(CMD_KICK, 32'd1012, 16383, 8'd1, 32'd913);
		queue_tick(CMD_KICK, 32'd1016, -16384, 8'd9, 32'd1016);
		queue_tick(CMD_KICK, 32'd1020, 320, 8'd0, 32'd1020);
		queue_tick(CMD_KICK, 32'd1024, 320, 8'd7, 32'd924);
		queue_tick(CMD_KICK, 32'd1025, -640, 8'd7, 32'd1030);
		queue_tick(CMD_STOP, 32'd1026, 0, 8'd7, 32'd1026);
		queue_tick(CMD_KICK, 32'd500, 11520, 8'd50, 32'd0);
		queue_tick(CMD_KICK, 32'd504, 100, 8'd50, 32'd504);
		queue_tick(CMD_STOP, 32'd505, 0, 8'd50, 32'd505);
		queue_tick(CMD_KICK, 32'hFFFF_FFFE, 11520, 8'd255, 32'hFFFF_FFF0);
		queue_tick(CMD_KICK, 32'd2, -11520, 8'd255, 32'hFFFF_FFFF);
		queue_tick(CMD_KICK, 32'd6, -5000, 8'd255, 32'd6);
		queue_tick(CMD_KICK, 32'd10, 11000, 8'd255, 32'd10);
		queue_tick(CMD_KICK, 32'd14, 15360, 8'd255, 32'd14);
		queue_tick(CMD_KICK, 32'd18, 7680, 8'd255, 32'd18);
		queue_tick(CMD_KICK, 32'hFFFF_FFFF, 0, 8'd128, 32'hFFFF_FFFF);
		queue_tick(CMD_STOP, 32'hFFFF_FFFF, -1, 8'd255, 32'hFFFF_FFFF);
		settle();

		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: put_setting(120, 40, 4, 240, 100, 256, 60, 0);
				1: put_setting(255, 255, 65535, 255, 65535, 32767, 255, 255);
				2: put_setting(0, 0, 0, 0, 0, -32768, 0, -255);
				3: put_setting(200, 30, 0, 100, 500, -32768, 255, -255); // start above final
				4: put_setting(0, 255, 1, 255, 65535, 32767, 200, 100);
				5: put_setting(60, 7, 10, 220, 150, -300, 90, -32);
				default: put_setting($urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 20), $urandom_range(0, 255), $urandom_range(0, 400),
					int'($urandom_range(0, 65535)) - 32768, $urandom_range(0, 255),
					int'($urandom_range(0, 510)) - 255);
			endcase
			write_setting();
			make_traffic(PHASE_TICKS);
			settle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (drive_due.size() != 0) begin
			$error("%0d predicted drive words never came out", drive_due.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("kick_ramp_heading_hold_mixer_core_test: done, clean");
		else
			$display("kick_ramp_heading_hold_mixer_core_test: done, errors");
		$finish;
	end

endmodule

// File: sim.f
rtl/krhm_pkg.sv
rtl/krhm_cfg.sv
rtl/krhm_ctrl.sv
rtl/krhm_dp.sv
rtl/kick_ramp_heading_hold_mixer_core.sv
rtl/krhm_checker.sv
bench/kick_ramp_heading_hold_mixer_core_test.sv
